>>> sv/sasi_pkg.sv
// Shared types, widths and codes for the sorted insert table.
// Used by the channel interfaces and by the top level; depends on nothing.
package sasi_pkg;

    localparam int C_DEFAULT_DEPTH = 64;
    localparam int C_MAX_SHIFTS    = 4;

    localparam int C_REQ_W     = 2;
    localparam int C_VAL_W     = 32;
    localparam int C_NORM_W    = 32;
    localparam int C_POS_W     = 6;
    localparam int C_ORD_W     = 6;
    localparam int C_CNT_W     = 7;
    localparam int C_STAT_W    = 2;
    localparam int C_MODE_W    = 3;
    localparam int C_SCNT_W    = 3;
    localparam int C_CFG_IDX_W = 3;
    localparam int C_CFG_DAT_W = 32;

    // Request codes.
    localparam logic [C_REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [C_REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [C_REQ_W-1:0] REQ_READ   = 2'd2;

    // Result status codes.
    localparam logic [C_STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [C_STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [C_STAT_W-1:0] STAT_RANGE = 2'd2;

    // Order modes.
    localparam logic [C_MODE_W-1:0] MODE_SMALLEST = 3'd0;
    localparam logic [C_MODE_W-1:0] MODE_LARGEST  = 3'd1;
    localparam logic [C_MODE_W-1:0] MODE_ABOVE    = 3'd2;
    localparam logic [C_MODE_W-1:0] MODE_BELOW    = 3'd3;
    localparam logic [C_MODE_W-1:0] MODE_ABSOLUTE = 3'd4;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] CFG_TARGET_MODE = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SHIFT_COUNT = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SHIFT_ZERO  = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SHIFT_ONE   = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SHIFT_TWO   = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SHIFT_THREE = 3'd5;

    typedef struct packed {
        logic signed [C_VAL_W-1:0] value;
        logic [C_NORM_W-1:0]       norm;
        logic [C_ORD_W-1:0]        order;
    } t_entry;

    typedef struct packed {
        logic [C_POS_W-1:0]        position;
        logic signed [C_VAL_W-1:0] value_out;
        logic [C_NORM_W-1:0]       norm_out;
        logic [C_ORD_W-1:0]        order_out;
        logic [C_CNT_W-1:0]        count_out;
        logic [C_STAT_W-1:0]       status;
    } t_rsp;

endpackage

>>> sv/sasi_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
// Depends on sasi_pkg for field widths.
interface sasi_req_if;
    import sasi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [C_REQ_W-1:0]        req_type;
    logic signed [C_VAL_W-1:0] new_value;
    logic [C_NORM_W-1:0]       new_norm;
    logic [C_POS_W-1:0]        read_index;
    modport source (output valid, req_type, new_value, new_norm, read_index, input ready);
    modport sink (input valid, req_type, new_value, new_norm, read_index, output ready);
endinterface

interface sasi_rsp_if;
    import sasi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [C_POS_W-1:0]        position;
    logic signed [C_VAL_W-1:0] value_out;
    logic [C_NORM_W-1:0]       norm_out;
    logic [C_ORD_W-1:0]        order_out;
    logic [C_CNT_W-1:0]        count_out;
    logic [C_STAT_W-1:0]       status;
    modport source (output valid, position, value_out, norm_out, order_out, count_out,
                    status, input ready);
    modport sink (input valid, position, value_out, norm_out, order_out, count_out,
                  status, output ready);
endinterface

interface sasi_cfg_if;
    import sasi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [C_CFG_IDX_W-1:0] index;
    logic [C_CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/shift_aware_sorted_insert_core.sv
// Sorted table of locked values with insertion by backward scan.
// Depends on sasi_pkg and the channel interfaces in sasi_if.sv.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   i_req    | in        | req_type, new_value, new_norm, read_index
//   o_rsp    | out       | position, value_out, norm_out, order_out,
//            |           | count_out, status
//   i_cfg    | in        | index, data (register write)
//
// An insert takes one step per entry moved up, each step a read and a write on
// the dual-port entry memory. A read waits for one memory read; clear, a dropped
// insert and a read beyond the count complete from the request alone.
// Synchronous active-low reset empties the table; entry contents are left as is.
// A new request is taken while the previous result waits in the output register;
// a finished request waits until that register is free.
module shift_aware_sorted_insert_core #(
    parameter int TABLE_DEPTH = sasi_pkg::C_DEFAULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sasi_req_if.sink    i_req,
    sasi_rsp_if.source  o_rsp,
    sasi_cfg_if.sink    i_cfg
);
    import sasi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW > 2) ? CW : 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_READ,
        ST_DONE
    } t_state;

    function automatic logic signed [C_VAL_W-1:0] f_shift_at(
        input logic [SW-1:0]               pos,
        input logic [1:0]                  nm1,
        input logic signed [C_VAL_W-1:0]   s0,
        input logic signed [C_VAL_W-1:0]   s1,
        input logic signed [C_VAL_W-1:0]   s2,
        input logic signed [C_VAL_W-1:0]   s3
    );
        logic [1:0]                k;
        logic signed [C_VAL_W-1:0] s;
        k = (pos < SW'(nm1)) ? 2'(pos) : nm1;
        unique case (k)
            2'd0: s = s0;
            2'd1: s = s1;
            2'd2: s = s2;
            default: s = s3;
        endcase
        return s;
    endfunction

    function automatic logic [C_VAL_W:0] f_absdiff(
        input logic signed [C_VAL_W-1:0] a,
        input logic signed [C_VAL_W-1:0] b
    );
        logic [C_VAL_W:0] d;
        d = {a[C_VAL_W-1], a} - {b[C_VAL_W-1], b};
        return d[C_VAL_W] ? (~d + 1'b1) : d;
    endfunction

    // Configuration registers.
    logic [C_MODE_W-1:0]       r_mode;
    logic [C_SCNT_W-1:0]       r_shift_count;
    logic signed [C_VAL_W-1:0] r_shift_zero;
    logic signed [C_VAL_W-1:0] r_shift_one;
    logic signed [C_VAL_W-1:0] r_shift_two;
    logic signed [C_VAL_W-1:0] r_shift_three;

    // Control and work registers.
    t_state                    r_state;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_i;
    logic signed [C_VAL_W-1:0] r_new_value;
    logic [C_NORM_W-1:0]       r_new_norm;
    logic [C_ORD_W-1:0]        r_order;
    logic signed [C_VAL_W-1:0] r_cur;
    logic [C_VAL_W:0]          r_dist_new;
    logic [C_POS_W-1:0]        r_read_pos;
    t_rsp                      r_res;
    t_rsp                      r_out;
    logic                      r_out_valid;

    // Entry memory.
    t_entry                    r_mem [TABLE_DEPTH];
    t_entry                    r_rd_q;

    logic [1:0]                nm1;
    logic [CW-1:0]             n_count;
    t_rsp                      n_res;
    logic signed [C_VAL_W-1:0] acc_shift;
    logic signed [C_VAL_W-1:0] pos_shift;
    logic                      scan_stop;
    logic                      scan_mode;
    logic                      req_fire;
    logic                      out_load;
    logic [AW-1:0]             mem_rd_addr;
    logic                      mem_wr_en;
    logic [AW-1:0]             mem_wr_addr;
    t_entry                    mem_wr_data;
    t_entry                    new_entry;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.position  = r_out.position;
    assign o_rsp.value_out = r_out.value_out;
    assign o_rsp.norm_out  = r_out.norm_out;
    assign o_rsp.order_out = r_out.order_out;
    assign o_rsp.count_out = r_out.count_out;
    assign o_rsp.status    = r_out.status;

    // Number of shifts in use, minus one, held to the supported range.
    always_comb begin
        if (r_shift_count == '0) begin
            nm1 = 2'd0;
        end else if (r_shift_count > C_SCNT_W'(C_MAX_SHIFTS)) begin
            nm1 = 2'(C_MAX_SHIFTS - 1);
        end else begin
            nm1 = 2'(r_shift_count - 3'd1);
        end
    end

    assign n_count   = r_count + CW'(1);
    assign scan_mode = (r_mode <= MODE_ABSOLUTE);
    assign new_entry = '{value: r_new_value, norm: r_new_norm, order: r_order};
    assign acc_shift = f_shift_at(SW'(r_count), nm1, r_shift_zero, r_shift_one,
                                  r_shift_two, r_shift_three);
    assign pos_shift = f_shift_at(SW'(r_i - AW'(1)), nm1, r_shift_zero, r_shift_one,
                                  r_shift_two, r_shift_three);

    // Result for a transaction that finishes without touching the table.
    always_comb begin
        n_res = '{position: '0, value_out: '0, norm_out: '0, order_out: '0,
                  count_out: C_CNT_W'(r_count), status: STAT_OK};
        unique case (i_req.req_type)
            REQ_CLEAR: begin
                n_res.count_out = '0;
            end
            REQ_INSERT: begin
                if (r_count == CW'(TABLE_DEPTH)) begin
                    n_res.status = STAT_FULL;
                end
            end
            REQ_READ: begin
                n_res.position = i_req.read_index;
                if ((CW + C_POS_W)'(i_req.read_index) >= (CW + C_POS_W)'(r_count)) begin
                    n_res.status = STAT_RANGE;
                end
            end
            default: ;
        endcase
    end

    // The memory output holds the entry just below the current gap during a scan.
    always_comb begin
        unique case (r_mode)
            MODE_SMALLEST: scan_stop = (r_new_value >= r_rd_q.value);
            MODE_LARGEST:  scan_stop = (r_new_value <= r_rd_q.value);
            MODE_ABOVE:    scan_stop = (pos_shift != r_cur) || (r_new_value >= r_rd_q.value);
            MODE_BELOW:    scan_stop = (pos_shift != r_cur) || (r_new_value <= r_rd_q.value);
            MODE_ABSOLUTE: scan_stop = (pos_shift != r_cur) ||
                                       (r_dist_new >= f_absdiff(r_rd_q.value, r_cur));
            default:       scan_stop = 1'b1;
        endcase
    end

    // Memory port control. While an entry moves up into the gap, the entry two
    // below the gap is already being read for the next step.
    always_comb begin
        mem_rd_addr = r_i - AW'(2);
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_i;
        mem_wr_data = new_entry;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.req_type == REQ_READ) begin
                    mem_rd_addr = AW'(i_req.read_index);
                end else begin
                    mem_rd_addr = AW'(r_count - CW'(1));
                end
            end
            ST_SCAN: begin
                mem_wr_en = 1'b1;
                if (!scan_stop) begin
                    mem_wr_data = r_rd_q;
                end
            end
            ST_PLACE: begin
                mem_wr_en = 1'b1;
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_q <= r_mem[mem_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_SMALLEST;
            r_shift_count <= C_SCNT_W'(1);
            r_shift_zero  <= '0;
            r_shift_one   <= '0;
            r_shift_two   <= '0;
            r_shift_three <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_TARGET_MODE: r_mode        <= i_cfg.data[C_MODE_W-1:0];
                    CFG_SHIFT_COUNT: r_shift_count <= i_cfg.data[C_SCNT_W-1:0];
                    CFG_SHIFT_ZERO:  r_shift_zero  <= i_cfg.data;
                    CFG_SHIFT_ONE:   r_shift_one   <= i_cfg.data;
                    CFG_SHIFT_TWO:   r_shift_two   <= i_cfg.data;
                    CFG_SHIFT_THREE: r_shift_three <= i_cfg.data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (req_fire) begin
                        r_res   <= n_res;
                        r_state <= ST_DONE;
                        unique case (i_req.req_type)
                            REQ_CLEAR: begin
                                r_count <= '0;
                            end
                            REQ_INSERT: begin
                                if (r_count != CW'(TABLE_DEPTH)) begin
                                    r_i         <= AW'(r_count);
                                    r_new_value <= i_req.new_value;
                                    r_new_norm  <= i_req.new_norm;
                                    r_order     <= C_ORD_W'(r_count);
                                    r_cur       <= acc_shift;
                                    r_dist_new  <= f_absdiff(i_req.new_value, acc_shift);
                                    if (!scan_mode || r_count == '0) begin
                                        r_state <= ST_PLACE;
                                    end else begin
                                        r_state <= ST_SCAN;
                                    end
                                end
                            end
                            REQ_READ: begin
                                r_read_pos <= i_req.read_index;
                                if ((CW + C_POS_W)'(i_req.read_index) <
                                    (CW + C_POS_W)'(r_count)) begin
                                    r_state <= ST_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_stop) begin
                        r_count <= n_count;
                        r_res   <= '{position: C_POS_W'(r_i), value_out: r_new_value,
                                     norm_out: r_new_norm, order_out: r_order,
                                     count_out: C_CNT_W'(n_count), status: STAT_OK};
                        r_state <= ST_DONE;
                    end else begin
                        r_i <= r_i - AW'(1);
                        if (r_i == AW'(1)) begin
                            r_state <= ST_PLACE;
                        end
                    end
                end
                ST_PLACE: begin
                    r_count <= n_count;
                    r_res   <= '{position: C_POS_W'(r_i), value_out: r_new_value,
                                 norm_out: r_new_norm, order_out: r_order,
                                 count_out: C_CNT_W'(n_count), status: STAT_OK};
                    r_state <= ST_DONE;
                end
                ST_READ: begin
                    r_res   <= '{position: r_read_pos, value_out: r_rd_q.value,
                                 norm_out: r_rd_q.norm, order_out: r_rd_q.order,
                                 count_out: C_CNT_W'(r_count), status: STAT_OK};
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sim/shift_aware_sorted_insert_core_tb.sv
// Self-checking testbench for the sorted insert table: a scoreboard class tracks
// the table contents and predicts every result. Needs sasi_pkg, the channel
// interfaces and shift_aware_sorted_insert_core.
`timescale 1ns / 100ps

module shift_aware_sorted_insert_core_tb;
    import sasi_pkg::*;

    localparam logic [C_REQ_W-1:0]  REQ_UNUSED     = 2'd3;
    localparam logic [C_MODE_W-1:0] MODE_UNDEFINED = 3'd6;

    localparam int LIMIT_CYCLES  = 800000;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 850;

    typedef struct packed {
        logic [C_REQ_W-1:0]        req_type;
        logic signed [C_VAL_W-1:0] new_value;
        logic [C_NORM_W-1:0]       new_norm;
        logic [C_POS_W-1:0]        read_index;
    } t_request;

    // Mirrors the table and its registers; one expected result per request.
    class table_scoreboard;
        logic signed [C_VAL_W-1:0] values [C_DEFAULT_DEPTH];
        logic [C_NORM_W-1:0]       norms [C_DEFAULT_DEPTH];
        logic [C_ORD_W-1:0]        orders [C_DEFAULT_DEPTH];
        int unsigned               count;
        logic [C_MODE_W-1:0]       mode;
        logic [C_SCNT_W-1:0]       shift_count;
        logic signed [C_VAL_W-1:0] shifts [C_MAX_SHIFTS];
        t_rsp                      expected_q [$];
        int                        mismatches, unexpected, checked;
        int                        n_insert, n_full, n_read, n_range, n_clear, n_unused;
        int unsigned               peak;
        bit [7:0]                  modes_seen;

        function new();
            foreach (values[i]) begin
                values[i] = '0;
                norms[i]  = '0;
                orders[i] = '0;
            end
            foreach (shifts[i]) shifts[i] = '0;
            count       = 0;
            mode        = MODE_SMALLEST;
            shift_count = 3'd1;
        endfunction

        function void write_register(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TARGET_MODE: mode        = data[C_MODE_W-1:0];
                CFG_SHIFT_COUNT: shift_count = data[C_SCNT_W-1:0];
                CFG_SHIFT_ZERO:  shifts[0]   = data;
                CFG_SHIFT_ONE:   shifts[1]   = data;
                CFG_SHIFT_TWO:   shifts[2]   = data;
                CFG_SHIFT_THREE: shifts[3]   = data;
                default: ;
            endcase
        endfunction

        // Positions past the last configured shift all use that last shift.
        function longint shift_of(int unsigned pos);
            int unsigned n, k;
            n = shift_count;
            if (n < 1) n = 1;
            if (n > C_MAX_SHIFTS) n = C_MAX_SHIFTS;
            k = n - 1;
            if (pos < k) k = pos;
            return longint'(shifts[k]);
        endfunction

        function longint distance(longint a, longint b);
            longint d;
            d = a - b;
            return (d < 0) ? -d : d;
        endfunction

        function void note_request(t_request r);
            t_rsp        exp;
            int unsigned slot, c;
            longint      nv, held, cur;
            bit          stop;
            exp = '0;
            case (r.req_type)
                REQ_CLEAR: begin
                    count = 0;
                    n_clear++;
                end
                REQ_INSERT: begin
                    n_insert++;
                    modes_seen[mode] = 1'b1;
                    if (count >= C_DEFAULT_DEPTH) begin
                        exp.status = STAT_FULL;
                        n_full++;
                    end else begin
                        nv   = longint'(r.new_value);
                        slot = count;
                        if (mode <= MODE_ABSOLUTE) begin
                            cur = shift_of(count);
                            while (slot > 0) begin
                                held = longint'(values[slot-1]);
                                if (mode == MODE_SMALLEST) stop = nv >= held;
                                else if (mode == MODE_LARGEST) stop = nv <= held;
                                else if (shift_of(slot-1) != cur) stop = 1'b1;
                                else if (mode == MODE_ABOVE) stop = nv >= held;
                                else if (mode == MODE_BELOW) stop = nv <= held;
                                else stop = distance(nv, cur) >= distance(held, cur);
                                if (stop) break;
                                slot--;
                            end
                        end
                        for (c = count; c > slot; c--) begin
                            values[c] = values[c-1];
                            norms[c]  = norms[c-1];
                            orders[c] = orders[c-1];
                        end
                        values[slot]  = r.new_value;
                        norms[slot]   = r.new_norm;
                        orders[slot]  = C_ORD_W'(count);
                        exp.position  = C_POS_W'(slot);
                        exp.value_out = r.new_value;
                        exp.norm_out  = r.new_norm;
                        exp.order_out = C_ORD_W'(count);
                        count++;
                    end
                end
                REQ_READ: begin
                    n_read++;
                    exp.position = r.read_index;
                    if (r.read_index < count) begin
                        exp.value_out = values[r.read_index];
                        exp.norm_out  = norms[r.read_index];
                        exp.order_out = orders[r.read_index];
                    end else begin
                        exp.status = STAT_RANGE;
                        n_range++;
                    end
                end
                default: n_unused++;
            endcase
            exp.count_out = C_CNT_W'(count);
            if (count > peak) peak = count;
            expected_q.push_back(exp);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            checked++;
            if (expected_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("Result %0d arrived with no request outstanding: %p",
                             checked, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.position !== exp.position || got.value_out !== exp.value_out ||
                got.norm_out !== exp.norm_out || got.order_out !== exp.order_out ||
                got.count_out !== exp.count_out || got.status !== exp.status) begin
                mismatches++;
                if (mismatches + unexpected <= 10) begin
                    $display("Result %0d mismatch", checked);
                    $display(
                        "  expected pos %0d value %h norm %h order %0d count %0d status %0d",
                        exp.position, exp.value_out, exp.norm_out, exp.order_out,
                        exp.count_out, exp.status);
                    $display(
                        "  actual   pos %0d value %h norm %h order %0d count %0d status %0d",
                        got.position, got.value_out, got.norm_out, got.order_out,
                        got.count_out, got.status);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int failures();
            return mismatches + unexpected + expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sasi_req_if req_if();
    sasi_rsp_if rsp_if();
    sasi_cfg_if cfg_if();

    shift_aware_sorted_insert_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    table_scoreboard sb = new();

    int burst_left;
    int gap_max;
    int rx_mode;
    int cycle_count;
    bit hold_request;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAILURE");
        $finish;
    end

    // Result sink: always open, or alternating open and stalled runs, plus one long hold on request.
    initial begin
        int run_left, hold_left;
        bit accepting;
        run_left  = 0;
        hold_left = 0;
        accepting = 1'b1;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    if (accepting && rx_mode != 0) begin
                        accepting = 1'b0;
                        run_left  = (rx_mode == 1) ? $urandom_range(1, 4) : $urandom_range(5, 70);
                    end else begin
                        accepting = 1'b1;
                        run_left  = $urandom_range(1, 25);
                    end
                end
                run_left--;
                rsp_if.ready <= accepting;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.position, rsp_if.value_out, rsp_if.norm_out,
                             rsp_if.order_out, rsp_if.count_out, rsp_if.status});
    end

    task automatic offer(input logic [C_REQ_W-1:0] kind, input logic [C_VAL_W-1:0] value,
                         input logic [C_NORM_W-1:0] norm, input logic [C_POS_W-1:0] idx);
        t_request r;
        int gap;
        r.req_type   = kind;
        r.new_value  = value;
        r.new_norm   = norm;
        r.read_index = idx;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.req_type   <= r.req_type;
        req_if.new_value  <= r.new_value;
        req_if.new_norm   <= r.new_norm;
        req_if.read_index <= r.read_index;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) @(posedge clk);
    endtask

    // Registers change only with the table idle; all six are written each time.
    task automatic configure(input logic [C_MODE_W-1:0] mode, input logic [C_SCNT_W-1:0] scount,
                             input logic [C_CFG_DAT_W-1:0] s0, input logic [C_CFG_DAT_W-1:0] s1,
                             input logic [C_CFG_DAT_W-1:0] s2, input logic [C_CFG_DAT_W-1:0] s3);
        logic [C_CFG_IDX_W-1:0] regs [6];
        logic [C_CFG_DAT_W-1:0] data [6];
        int i;
        regs = '{CFG_TARGET_MODE, CFG_SHIFT_COUNT, CFG_SHIFT_ZERO,
                 CFG_SHIFT_ONE, CFG_SHIFT_TWO, CFG_SHIFT_THREE};
        data = '{($urandom() & 32'hFFFF_FFF8) | mode, ($urandom() & 32'hFFFF_FFF8) | scount,
                 s0, s1, s2, s3};
        wait_idle();
        for (i = 0; i < 6; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[i];
            cfg_if.data  <= data[i];
            do @(posedge clk); while (!cfg_if.ready);
            sb.write_register(regs[i], data[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int                     phase, total, n_items, k, pick, delta;
        bit                     fill;
        logic [C_REQ_W-1:0]     kind;
        logic [C_MODE_W-1:0]    mode;
        logic [C_VAL_W-1:0]     value, prev_value, base;
        logic [C_VAL_W-1:0]     shift_pick [C_MAX_SHIFTS];
        logic [C_POS_W-1:0]     idx;

        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_CLEAR;
        req_if.new_value  <= '0;
        req_if.new_norm   <= '0;
        req_if.read_index <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_TARGET_MODE;
        cfg_if.data       <= '0;
        gap_max      = 0;
        rx_mode      = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        prev_value   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset configuration (ascending order).
        offer(REQ_READ, 32'h0, 32'h0, 6'd0);
        offer(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        offer(REQ_INSERT, 32'h8000_0000, 32'h0, 6'h3F);
        offer(REQ_INSERT, 32'h0, 32'h0001_0000, 6'd0);
        offer(REQ_INSERT, 32'h0, 32'h1, 6'd0);
        offer(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 6'd0);
        offer(REQ_READ, 32'h1234_5678, 32'h9ABC_DEF0, 6'd0);
        offer(REQ_READ, 32'h0, 32'h0, 6'd4);
        offer(REQ_READ, 32'h0, 32'h0, 6'd5);
        offer(REQ_READ, 32'h0, 32'h0, 6'h3F);
        offer(REQ_UNUSED, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 6'h2A);
        offer(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        offer(REQ_READ, 32'h0, 32'h0, 6'd0);
        // Descending order; a shift count above the maximum acts as the maximum.
        configure(MODE_LARGEST, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        offer(REQ_INSERT, 32'h5, 32'h10, 6'd0);
        offer(REQ_INSERT, 32'h7FFF_FFFF, 32'h20, 6'd0);
        offer(REQ_INSERT, 32'h8000_0000, 32'h30, 6'd0);
        offer(REQ_INSERT, 32'h5, 32'h40, 6'd0);
        // Both configured shifts are equal, so the position's shift never changes during the scan.
        configure(MODE_ABOVE, 3'd2, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        offer(REQ_INSERT, 32'h0000_0010, 32'h50, 6'd0);
        offer(REQ_INSERT, 32'h8000_0000, 32'h60, 6'd0);
        offer(REQ_INSERT, 32'h0000_0008, 32'h70, 6'd0);
        // Shift count zero acts as one; equal distances on both sides of the shift.
        configure(MODE_ABSOLUTE, 3'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        offer(REQ_INSERT, 32'h0001_0100, 32'h80, 6'd0);
        offer(REQ_INSERT, 32'h0000_FF00, 32'h90, 6'd0);
        // An undefined mode appends without scanning.
        configure(MODE_UNDEFINED, 3'd1, 32'h0, 32'h0, 32'h0, 32'h0);
        offer(REQ_INSERT, 32'h8000_0000, 32'hA0, 6'd0);
        offer(REQ_READ, 32'h0, 32'h0, 6'd9);

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            fill = (phase % 4 == 1);
            if (phase < 8) mode = phase[C_MODE_W-1:0];
            else if ($urandom_range(0, 9) < 8) mode = C_MODE_W'($urandom_range(0, 4));
            else mode = C_MODE_W'($urandom_range(5, 7));
            base = $urandom();
            for (k = 0; k < C_MAX_SHIFTS; k++) begin
                case ($urandom_range(0, 5))
                    0: shift_pick[k] = 32'h8000_0000;
                    1: shift_pick[k] = 32'h7FFF_FFFF;
                    2: shift_pick[k] = $urandom();
                    default: shift_pick[k] = base + $urandom_range(0, 2) * 32'h0002_0000;
                endcase
            end
            configure(mode, C_SCNT_W'($urandom_range(0, 7)), shift_pick[0], shift_pick[1],
                      shift_pick[2], shift_pick[3]);
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 12;
                default: gap_max = 80;
            endcase
            rx_mode = $urandom_range(0, 2);
            if (phase == 2) begin
                // Sink holds off while the source keeps pushing, so the input backs up.
                hold_request = 1'b1;
                gap_max = 0;
            end
            n_items = fill ? 100 : $urandom_range(40, 70);
            if (!fill && $urandom_range(0, 1) == 1) begin
                offer(REQ_CLEAR, $urandom(), $urandom(), C_POS_W'($urandom_range(0, 63)));
                total++;
            end
            for (k = 0; k < n_items; k++) begin
                pick = $urandom_range(0, 99);
                if (fill ? pick < 90 : pick < 55) kind = REQ_INSERT;
                else if (fill || pick < 88) kind = REQ_READ;
                else if (pick < 95) kind = REQ_CLEAR;
                else kind = REQ_UNUSED;
                case ($urandom_range(0, 9))
                    0: value = 32'h7FFF_FFFF;
                    1: value = 32'h8000_0000;
                    2, 3: value = $urandom();
                    4: value = prev_value;
                    default: begin
                        delta = $urandom_range(0, 32'h0004_0000);
                        value = shift_pick[$urandom_range(0, 3)] + delta - 32'h0002_0000;
                    end
                endcase
                prev_value = value;
                if (sb.count > 0 && $urandom_range(0, 3) != 0)
                    idx = C_POS_W'($urandom_range(0, sb.count - 1));
                else
                    idx = C_POS_W'($urandom_range(0, 63));
                offer(kind, value, $urandom(), idx);
                total++;
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d inserts (%0d when full), %0d reads (%0d past the end),",
                 sb.checked, sb.n_insert, sb.n_full, sb.n_read, sb.n_range);
        $display("%0d clears, %0d unused codes, insert modes %b, peak fill %0d of %0d entries",
                 sb.n_clear, sb.n_unused, sb.modes_seen, sb.peak, C_DEFAULT_DEPTH);
        if (sb.failures() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
sv/sasi_pkg.sv
sv/sasi_if.sv
sv/shift_aware_sorted_insert_core.sv
sim/shift_aware_sorted_insert_core_tb.sv
